// File: hw/rtl/egrt_pkg.sv
// ----------------------------------------------------------------------------
// egrt_pkg
// Shared types and constants of the epoch grace reclaim tracker.
// ----------------------------------------------------------------------------
package egrt_pkg;

    localparam int EPOCH_W  = 32;
    localparam int HANDLE_W = 16;
    localparam int TID_W    = 4;
    localparam int REQ_W    = 3;
    localparam int ACT_W    = 5;
    localparam int PEND_W   = 7;

    localparam logic [ACT_W-1:0]   ACTIVE_RST = 5'd6;
    localparam logic [EPOCH_W-1:0] EPOCH_RST  = 32'd1;
    localparam logic [EPOCH_W-1:0] EPOCH_MAX  = 32'hFFFF_FFFF;

    // request kinds
    typedef enum logic [REQ_W-1:0] {
        REQ_ENTER   = 3'd0,
        REQ_EXIT    = 3'd1,
        REQ_ADVANCE = 3'd2,
        REQ_RETIRE  = 3'd3,
        REQ_RECLAIM = 3'd4
    } t_req;

    // one retired table entry
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [EPOCH_W-1:0]  tag;
    } t_ret_entry;

    // commands to the reader unit
    typedef struct packed {
        logic enter;
        logic leave;
        logic scan;
    } t_rd_ctl;

    // status from the reader unit
    typedef struct packed {
        logic               done;
        logic [EPOCH_W-1:0] min_epoch;
    } t_rd_sts;

endpackage

// File: hw/rtl/epoch_grace_reclaim_tracker.sv
// ----------------------------------------------------------------------------
// epoch_grace_reclaim_tracker
// Epoch-based reclamation tracker: global epoch, reader epochs and a table
// of retired handles; reclaim frees every handle whose grace period is done.
// ----------------------------------------------------------------------------
//  channel   | dir | signals                  | contents (low bit up)
//  ----------+-----+--------------------------+------------------------------
//  s_axis    | in  | tvalid tready tdata tuser| tdata: thread_id, handle
//            |     |                          | tuser: req_type
//  m_axis    | out | tvalid tready tdata tuser| tdata: freed_handle,
//            |     | tlast                    |   retire_dropped, pending_count,
//            |     |                          |   current_epoch; tuser: freed_valid
//  cfg       | in  | i_cfg_valid o_cfg_ready  | i_cfg_data: active_threads
//
//  Enter, exit, advance, retire: result registered at transfer, shown the next cycle.
//  Reclaim: a reader scan over min(active_threads, MAX_THREADS) slots, then
//  each entry is read and checked, and each freed entry gets the tail entry
//  moved into its hole, on the retired table memory (one access per cycle);
//  a final result closes the run.
//  Reset is synchronous, active low; no clearing pass is needed.
//  A full output register stalls result delivery and input acceptance.
// ----------------------------------------------------------------------------
module epoch_grace_reclaim_tracker #(
    parameter int MAX_THREADS   = 16,
    parameter int RETIRED_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [3:0] thread_id, [19:4] handle
    input  logic [2:0]  s_axis_tuser,   // [2:0] req_type
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [15:0] freed_handle, [16] retire_dropped,
                                        // [23:17] pending_count, [55:24] current_epoch
    output logic [0:0]  m_axis_tuser,   // [0] freed_valid
    output logic        m_axis_tlast,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data      // active_threads
);

    localparam int TAW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
    localparam int RAW = $clog2(RETIRED_DEPTH);
    localparam int RCW = $clog2(RETIRED_DEPTH + 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MIN  = 6'b000010,
        S_RD   = 6'b000100,
        S_CHK  = 6'b001000,
        S_MOVE = 6'b010000,
        S_FIN  = 6'b100000
    } t_state;

    t_state                            r_state, n_state;
    logic [egrt_pkg::EPOCH_W-1:0]      r_epoch, n_epoch;
    logic [RCW-1:0]                    r_count, n_count;
    logic [RCW-1:0]                    r_i, n_i;
    logic [egrt_pkg::ACT_W-1:0]        r_active;
    logic [egrt_pkg::HANDLE_W-1:0]     r_fh, n_fh;
    logic                              r_held, n_held;
    logic [egrt_pkg::HANDLE_W-1:0]     r_hold_h, n_hold_h;
    logic [RCW-1:0]                    r_hold_cnt, n_hold_cnt;

    egrt_pkg::t_ret_entry              r_mem [RETIRED_DEPTH];
    egrt_pkg::t_ret_entry              r_rd_q;

    // output register
    logic                              r_o_valid;
    logic                              r_o_freed;
    logic [egrt_pkg::HANDLE_W-1:0]     r_o_handle;
    logic                              r_o_drop;
    logic [egrt_pkg::PEND_W-1:0]       r_o_pend;
    logic [egrt_pkg::EPOCH_W-1:0]      r_o_epoch;
    logic                              r_o_last;

    // per-cycle controls
    logic                              out_free;
    logic                              accept;
    egrt_pkg::t_req                    req;
    logic [egrt_pkg::TID_W-1:0]        tid;
    logic [egrt_pkg::HANDLE_W-1:0]     hnd;
    logic                              tid_ok;
    logic [RCW-1:0]                    cnt_m1;
    logic                              mem_we;
    logic [RAW-1:0]                    mem_waddr;
    egrt_pkg::t_ret_entry              mem_wdata;
    logic                              mem_re;
    logic [RAW-1:0]                    mem_raddr;
    egrt_pkg::t_rd_ctl                 rd_ctl;
    egrt_pkg::t_rd_sts                 rd_sts;
    logic                              emit_en;
    logic                              e_freed;
    logic [egrt_pkg::HANDLE_W-1:0]     e_h;
    logic                              e_drop;
    logic [egrt_pkg::PEND_W-1:0]       e_pend;
    logic [egrt_pkg::EPOCH_W-1:0]      e_epoch;
    logic                              e_last;

    assign out_free      = !r_o_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign req           = egrt_pkg::t_req'(s_axis_tuser);
    assign tid           = s_axis_tdata[3:0];
    assign hnd           = s_axis_tdata[19:4];
    assign tid_ok        = ({3'b000, tid} < 7'(MAX_THREADS));
    assign cnt_m1        = r_count - RCW'(1);
    assign o_cfg_ready   = 1'b1;

    egrt_reader_unit #(
        .MAX_THREADS (MAX_THREADS)
    ) u_reader (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (rd_ctl),
        .i_tid    (TAW'(tid)),
        .i_epoch  (r_epoch),
        .i_active (r_active),
        .o_sts    (rd_sts)
    );

    // request decode and reclaim sequencer
    always_comb begin
        n_state    = r_state;
        n_epoch    = r_epoch;
        n_count    = r_count;
        n_i        = r_i;
        n_fh       = r_fh;
        n_held     = r_held;
        n_hold_h   = r_hold_h;
        n_hold_cnt = r_hold_cnt;
        mem_we     = 1'b0;
        mem_waddr  = r_i[RAW-1:0];
        mem_wdata  = r_rd_q;
        mem_re     = 1'b0;
        mem_raddr  = r_i[RAW-1:0];
        rd_ctl     = '0;
        emit_en    = 1'b0;
        e_freed    = 1'b0;
        e_h        = '0;
        e_drop     = 1'b0;
        e_pend     = egrt_pkg::PEND_W'(r_count);
        e_epoch    = r_epoch;
        e_last     = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    emit_en = 1'b1;
                    unique case (req)
                        egrt_pkg::REQ_ENTER: begin
                            rd_ctl.enter = tid_ok;
                        end
                        egrt_pkg::REQ_EXIT: begin
                            rd_ctl.leave = tid_ok;
                        end
                        egrt_pkg::REQ_ADVANCE: begin
                            if (r_epoch != egrt_pkg::EPOCH_MAX) begin
                                n_epoch = r_epoch + egrt_pkg::EPOCH_W'(1);
                            end
                        end
                        egrt_pkg::REQ_RETIRE: begin
                            if (r_count < RCW'(RETIRED_DEPTH)) begin
                                mem_we    = 1'b1;
                                mem_waddr = r_count[RAW-1:0];
                                mem_wdata = '{handle: hnd, tag: r_epoch};
                                n_count   = r_count + RCW'(1);
                            end else begin
                                e_drop = 1'b1;
                            end
                        end
                        egrt_pkg::REQ_RECLAIM: begin
                            emit_en     = 1'b0;
                            rd_ctl.scan = 1'b1;
                            n_i         = '0;
                            n_held      = 1'b0;
                            n_state     = S_MIN;
                        end
                        default: ;
                    endcase
                    e_pend  = egrt_pkg::PEND_W'(n_count);
                    e_epoch = n_epoch;
                end
            end
            S_MIN: begin
                if (rd_sts.done) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                if (r_i < r_count) begin
                    mem_re    = 1'b1;
                    mem_raddr = r_i[RAW-1:0];
                    n_state   = S_CHK;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_CHK: begin
                // grace done when no busy reader entered before the tag
                if (r_rd_q.tag <= rd_sts.min_epoch) begin
                    n_fh      = r_rd_q.handle;
                    mem_re    = 1'b1;
                    mem_raddr = cnt_m1[RAW-1:0];
                    n_state   = S_MOVE;
                end else begin
                    n_i     = r_i + RCW'(1);
                    n_state = S_RD;
                end
            end
            S_MOVE: begin
                // last entry fills the hole; earlier freed result goes out
                if (!r_held || out_free) begin
                    mem_we     = 1'b1;
                    mem_waddr  = r_i[RAW-1:0];
                    mem_wdata  = r_rd_q;
                    n_count    = cnt_m1;
                    emit_en    = r_held;
                    e_freed    = 1'b1;
                    e_h        = r_hold_h;
                    e_pend     = egrt_pkg::PEND_W'(r_hold_cnt);
                    e_last     = 1'b0;
                    n_held     = 1'b1;
                    n_hold_h   = r_fh;
                    n_hold_cnt = cnt_m1;
                    n_state    = S_RD;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    emit_en = 1'b1;
                    e_freed = r_held;
                    e_h     = r_held ? r_hold_h : '0;
                    e_last  = 1'b1;
                    n_held  = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // retired table memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_q <= r_mem[mem_raddr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_epoch  <= egrt_pkg::EPOCH_RST;
            r_count  <= '0;
            r_i      <= '0;
            r_held   <= 1'b0;
            r_active <= egrt_pkg::ACTIVE_RST;
        end else begin
            r_state <= n_state;
            r_epoch <= n_epoch;
            r_count <= n_count;
            r_i     <= n_i;
            r_held  <= n_held;
            if (i_cfg_valid) begin
                r_active <= i_cfg_data;
            end
        end
    end

    // held result payload
    always_ff @(posedge i_clk) begin
        r_fh       <= n_fh;
        r_hold_h   <= n_hold_h;
        r_hold_cnt <= n_hold_cnt;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (emit_en) begin
            r_o_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_en) begin
            r_o_freed  <= e_freed;
            r_o_handle <= e_h;
            r_o_drop   <= e_drop;
            r_o_pend   <= e_pend;
            r_o_epoch  <= e_epoch;
            r_o_last   <= e_last;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {r_o_epoch, r_o_pend, r_o_drop, r_o_handle};
    assign m_axis_tuser  = r_o_freed;
    assign m_axis_tlast  = r_o_last;

endmodule

// File: hw/rtl/egrt_reader_unit.sv
// ----------------------------------------------------------------------------
// egrt_reader_unit
// Per-thread read-section epochs in a synchronous memory, idle marks in
// flops, and a one-slot-per-cycle scan for the oldest busy reader epoch.
// ----------------------------------------------------------------------------
module egrt_reader_unit #(
    parameter  int MAX_THREADS = 16,
    localparam int TAW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  egrt_pkg::t_rd_ctl            i_ctl,
    input  logic [TAW-1:0]               i_tid,
    input  logic [egrt_pkg::EPOCH_W-1:0] i_epoch,
    input  logic [egrt_pkg::ACT_W-1:0]   i_active,
    output egrt_pkg::t_rd_sts            o_sts
);

    localparam int CW = $clog2(MAX_THREADS + 1);

    logic [egrt_pkg::EPOCH_W-1:0] r_mem [MAX_THREADS];
    logic [MAX_THREADS-1:0]       r_idle;
    logic                         r_scan;
    logic                         r_pend;
    logic                         r_pend_idle;
    logic                         r_done;
    logic [CW-1:0]                r_ptr;
    logic [CW-1:0]                r_limit;
    logic [egrt_pkg::EPOCH_W-1:0] r_rd_q;
    logic [egrt_pkg::EPOCH_W-1:0] r_min;

    logic [6:0]    act_w;
    logic [6:0]    max_w;
    logic [CW-1:0] act_clamp;
    logic          issue;

    // slots checked: active count clamped to the slot count
    assign act_w     = 7'(i_active);
    assign max_w     = 7'(MAX_THREADS);
    assign act_clamp = CW'((act_w > max_w) ? max_w : act_w);
    assign issue     = r_scan && (r_ptr < r_limit);

    // epoch memory: write on enter, read one slot per scan cycle
    always_ff @(posedge i_clk) begin
        if (i_ctl.enter) begin
            r_mem[i_tid] <= i_epoch;
        end
        if (issue) begin
            r_rd_q      <= r_mem[r_ptr[TAW-1:0]];
            r_pend_idle <= r_idle[r_ptr[TAW-1:0]];
        end
    end

    // idle marks and scan sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle  <= '1;
            r_scan  <= 1'b0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
            r_ptr   <= '0;
            r_limit <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.enter) begin
                r_idle[i_tid] <= 1'b0;
            end
            if (i_ctl.leave) begin
                r_idle[i_tid] <= 1'b1;
            end
            if (i_ctl.scan) begin
                r_scan  <= 1'b1;
                r_ptr   <= '0;
                r_limit <= act_clamp;
                r_pend  <= 1'b0;
            end else if (r_scan) begin
                r_pend <= issue;
                if (issue) begin
                    r_ptr <= r_ptr + CW'(1);
                end else if (!r_pend) begin
                    r_scan <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // running minimum; all ones when no busy reader, which passes every tag
    always_ff @(posedge i_clk) begin
        if (i_ctl.scan) begin
            r_min <= '1;
        end else if (r_pend && !r_pend_idle && (r_rd_q < r_min)) begin
            r_min <= r_rd_q;
        end
    end

    assign o_sts.done      = r_done;
    assign o_sts.min_epoch = r_min;

endmodule

// File: hw/rtl/egrt_checker.sv
// ----------------------------------------------------------------------------
// egrt_checker
// Port-level checks of the epoch grace reclaim tracker, bound to the top.
// ----------------------------------------------------------------------------
module egrt_checker #(
    parameter int RETIRED_DEPTH = 64
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [2:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");

    // every request but reclaim yields one final result in the next cycle
    a_quick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready &&
         (s_axis_tuser != 3'(egrt_pkg::REQ_RECLAIM))) |=> (m_axis_tvalid && m_axis_tlast))
        else $error("missing single result after non-reclaim transfer");

    // no freed handle: handle field is zero
    a_plain_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[15:0] == 16'd0))
        else $error("handle set on a result without a freed handle");

    // a freed handle never comes with a dropped retire
    a_freed_nodrop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> !m_axis_tdata[16])
        else $error("freed result flags a dropped retire");

    // pending count stays within the table
    a_pend_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[23:17] <= 7'(RETIRED_DEPTH)))
        else $error("pending count above table depth");

endmodule

bind epoch_grace_reclaim_tracker egrt_checker #(
    .RETIRED_DEPTH (RETIRED_DEPTH)
) u_egrt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// File: tb/sv/epoch_grace_reclaim_tracker_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// epoch_grace_reclaim_tracker_tb
// Self-checking bench for the epoch grace reclaim tracker. A short directed
// table runs first: reset values, epoch advance, read sections, retires
// filling the table to overflow, reclaim with and without readers, and
// unknown request kinds. Random phases follow under different slot counts,
// including zero and a value above the slot limit. Every result transfer is
// compared field by field against an in-bench model or a hand-written typed row.
// ----------------------------------------------------------------------------
module epoch_grace_reclaim_tracker_tb;

    localparam int N_SLOTS   = 16;
    localparam int TABLE_LEN = 64;
    localparam int CYCLE_CAP = 10_000_000;
    localparam int N_STEPS   = 25;
    localparam int N_PHASES  = 7;

    // request kinds the block does not know
    localparam logic [egrt_pkg::REQ_W-1:0] REQ_BAD_LO  = 3'd5;
    localparam logic [egrt_pkg::REQ_W-1:0] REQ_BAD_MID = 3'd6;
    localparam logic [egrt_pkg::REQ_W-1:0] REQ_BAD_HI  = 3'd7;

    // random phase styles
    localparam int MODE_MIX  = 0;
    localparam int MODE_FILL = 1;
    localparam int CFG_DRAW  = -1;

    // one result as seen on the output stream
    typedef struct packed {
        logic                          freed_valid;
        logic [egrt_pkg::HANDLE_W-1:0] freed_handle;
        logic                          dropped;
        logic [egrt_pkg::PEND_W-1:0]   pending;
        logic [egrt_pkg::EPOCH_W-1:0]  epoch;
        logic                          last;
    } t_outcome;

    // one row of the directed table
    typedef struct packed {
        logic [egrt_pkg::REQ_W-1:0]    req;
        logic [egrt_pkg::TID_W-1:0]    tid;
        logic [egrt_pkg::HANDLE_W-1:0] handle;
        logic [7:0]                    reps;
        logic                          typed;
        t_outcome                      want;
    } t_step;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;   // [3:0] thread_id, [19:4] handle
    logic [2:0]  s_axis_tuser = '0;   // [2:0] req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;        // [15:0] freed_handle, [16] retire_dropped,
                                      // [23:17] pending_count, [55:24] current_epoch
    logic [0:0]  m_axis_tuser;        // [0] freed_valid
    logic        m_axis_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [4:0]  i_cfg_data = '0;     // active_threads

    epoch_grace_reclaim_tracker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // tracker model state
    logic [egrt_pkg::EPOCH_W-1:0]  epoch_now;
    logic                          slot_idle  [N_SLOTS];
    logic [egrt_pkg::EPOCH_W-1:0]  slot_epoch [N_SLOTS];
    logic [egrt_pkg::HANDLE_W-1:0] ret_handle [TABLE_LEN];
    logic [egrt_pkg::EPOCH_W-1:0]  ret_tag    [TABLE_LEN];
    int                            ret_count;
    logic [egrt_pkg::ACT_W-1:0]    slots_checked;

    t_outcome outcomes_due [$];
    t_step    plan [N_STEPS];
    int       fail_count = 0;
    int       cycle_count = 0;
    bit       no_idle = 1'b0;
    t_outcome got, want;

    // clock, reset and run limit
    initial begin
        fork
            forever #5 i_clk = ~i_clk;
            begin
                repeat (12) @(posedge i_clk);
                i_rst_n <= 1'b1;
            end
            forever begin
                @(posedge i_clk);
                cycle_count++;
                if (cycle_count >= CYCLE_CAP) begin
                    $display("epoch_grace_reclaim_tracker verification failed");
                    $finish;
                end
            end
        join
    end

    // grace period check over the monitored slots
    function automatic bit grace_over(logic [egrt_pkg::EPOCH_W-1:0] tag);
        int n;
        n = (slots_checked > N_SLOTS) ? N_SLOTS : int'(slots_checked);
        for (int i = 0; i < n; i++)
            if (!slot_idle[i] && slot_epoch[i] < tag) return 1'b0;
        return 1'b1;
    endfunction

    task automatic queue_outcome(logic fv, logic [egrt_pkg::HANDLE_W-1:0] fh,
                                 logic drop, logic lst);
        t_outcome o;
        o.freed_valid  = fv;
        o.freed_handle = fh;
        o.dropped      = drop;
        o.pending      = egrt_pkg::PEND_W'(ret_count);
        o.epoch        = epoch_now;
        o.last         = lst;
        outcomes_due.push_back(o);
    endtask

    // update the model with one accepted request and queue its results
    task automatic track_request(logic [egrt_pkg::REQ_W-1:0] req,
                                 logic [egrt_pkg::TID_W-1:0] tid,
                                 logic [egrt_pkg::HANDLE_W-1:0] h);
        logic                          drop;
        logic [egrt_pkg::HANDLE_W-1:0] fh;
        bit                            freed;
        int                            nfreed;
        drop = 1'b0;
        case (req)
            egrt_pkg::REQ_ENTER: begin
                slot_epoch[tid] = epoch_now;
                slot_idle[tid]  = 1'b0;
            end
            egrt_pkg::REQ_EXIT: slot_idle[tid] = 1'b1;
            egrt_pkg::REQ_ADVANCE: if (epoch_now != egrt_pkg::EPOCH_MAX) epoch_now++;
            egrt_pkg::REQ_RETIRE: begin
                if (ret_count < TABLE_LEN) begin
                    ret_handle[ret_count] = h;
                    ret_tag[ret_count]    = epoch_now;
                    ret_count++;
                end else begin
                    drop = 1'b1;
                end
            end
            egrt_pkg::REQ_RECLAIM: begin
                nfreed = 0;
                freed  = 1'b1;
                // free the first finished entry, move the tail entry in, rescan
                while (freed) begin
                    freed = 1'b0;
                    for (int i = 0; i < ret_count; i++) begin
                        if (grace_over(ret_tag[i])) begin
                            fh            = ret_handle[i];
                            ret_handle[i] = ret_handle[ret_count-1];
                            ret_tag[i]    = ret_tag[ret_count-1];
                            ret_count--;
                            queue_outcome(1'b1, fh, 1'b0, 1'b0);
                            nfreed++;
                            freed = 1'b1;
                            break;
                        end
                    end
                end
                if (nfreed == 0) queue_outcome(1'b0, '0, 1'b0, 1'b1);
                else outcomes_due[outcomes_due.size()-1].last = 1'b1;
                return;
            end
            default: ;
        endcase
        queue_outcome(1'b0, '0, drop, 1'b1);
    endtask

    // one input transfer after a random gap
    task automatic send_request(logic [egrt_pkg::REQ_W-1:0] req,
                                logic [egrt_pkg::TID_W-1:0] tid,
                                logic [egrt_pkg::HANDLE_W-1:0] h);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, h, tid};
        s_axis_tuser  <= req;
        do @(posedge i_clk); while (!s_axis_tready);
        track_request(req, tid, h);
    endtask

    // wait until every queued result has arrived, then let the block settle
    task automatic drain(int settle);
        s_axis_tvalid <= 1'b0;
        while (outcomes_due.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_slots(logic [egrt_pkg::ACT_W-1:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        slots_checked = v;
    endtask

    // output side back-pressure
    initial begin
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = no_idle ? 0 : $urandom_range(0, 19);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    // result checking
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.freed_valid  = m_axis_tuser[0];
            got.freed_handle = m_axis_tdata[15:0];
            got.dropped      = m_axis_tdata[16];
            got.pending      = m_axis_tdata[23:17];
            got.epoch        = m_axis_tdata[55:24];
            got.last         = m_axis_tlast;
            if (outcomes_due.size() == 0) begin
                $display("%0t unexpected result: expected none, got %h", $time, got);
                fail_count++;
            end else begin
                want = outcomes_due.pop_front();
                if (got.freed_valid !== want.freed_valid) begin
                    $display("%0t freed_valid: expected %0d, got %0d",
                             $time, want.freed_valid, got.freed_valid);
                    fail_count++;
                end
                if (got.freed_handle !== want.freed_handle) begin
                    $display("%0t freed_handle: expected %h, got %h",
                             $time, want.freed_handle, got.freed_handle);
                    fail_count++;
                end
                if (got.dropped !== want.dropped) begin
                    $display("%0t retire_dropped: expected %0d, got %0d",
                             $time, want.dropped, got.dropped);
                    fail_count++;
                end
                if (got.pending !== want.pending) begin
                    $display("%0t pending_count: expected %0d, got %0d",
                             $time, want.pending, got.pending);
                    fail_count++;
                end
                if (got.epoch !== want.epoch) begin
                    $display("%0t current_epoch: expected %h, got %h",
                             $time, want.epoch, got.epoch);
                    fail_count++;
                end
                if (got.last !== want.last) begin
                    $display("%0t tlast: expected %0d, got %0d",
                             $time, want.last, got.last);
                    fail_count++;
                end
            end
        end
    end

    // stimulus
    initial begin
        int phase_cfg   [N_PHASES];
        int phase_items [N_PHASES];
        int phase_mode  [N_PHASES];
        bit phase_burst [N_PHASES];
        int r;
        logic [egrt_pkg::REQ_W-1:0]    req;
        logic [egrt_pkg::TID_W-1:0]    tid;
        logic [egrt_pkg::HANDLE_W-1:0] h;

        epoch_now     = egrt_pkg::EPOCH_RST;
        ret_count     = 0;
        slots_checked = egrt_pkg::ACTIVE_RST;
        for (int i = 0; i < N_SLOTS; i++) begin
            slot_idle[i]  = 1'b1;
            slot_epoch[i] = '0;
        end

        // req, tid, handle, repeat, typed, {valid, handle, dropped, pending, epoch, last}
        plan = '{
            '{egrt_pkg::REQ_ADVANCE, 4'd0,  16'h0000, 8'd1,  1'b1,
              '{1'b0, 16'h0, 1'b0, 7'd0, 32'd2, 1'b1}},
            '{egrt_pkg::REQ_RECLAIM, 4'd0,  16'h0000, 8'd1,  1'b1,
              '{1'b0, 16'h0, 1'b0, 7'd0, 32'd2, 1'b1}},
            '{egrt_pkg::REQ_ENTER,   4'd0,  16'h0000, 8'd1,  1'b1,
              '{1'b0, 16'h0, 1'b0, 7'd0, 32'd2, 1'b1}},
            '{egrt_pkg::REQ_RETIRE,  4'd0,  16'h0000, 8'd1,  1'b1,
              '{1'b0, 16'h0, 1'b0, 7'd1, 32'd2, 1'b1}},
            '{egrt_pkg::REQ_ADVANCE, 4'd0,  16'h0000, 8'd1,  1'b0, '0},
            '{egrt_pkg::REQ_RETIRE,  4'd0,  16'hFFFF, 8'd1,  1'b0, '0},
            '{egrt_pkg::REQ_ENTER,   4'd15, 16'h0000, 8'd1,  1'b0, '0},
            '{egrt_pkg::REQ_RECLAIM, 4'd0,  16'h0000, 8'd1,  1'b0, '0},
            '{egrt_pkg::REQ_EXIT,    4'd0,  16'h0000, 8'd1,  1'b0, '0},
            '{egrt_pkg::REQ_RECLAIM, 4'd0,  16'h0000, 8'd1,  1'b0, '0},
            '{egrt_pkg::REQ_ENTER,   4'd5,  16'h0000, 8'd1,  1'b0, '0},
            '{egrt_pkg::REQ_ADVANCE, 4'd0,  16'h0000, 8'd1,  1'b0, '0},
            '{egrt_pkg::REQ_RETIRE,  4'd0,  16'hA5A5, 8'd1,  1'b0, '0},
            '{egrt_pkg::REQ_RETIRE,  4'd0,  16'h5A5A, 8'd1,  1'b0, '0},
            '{egrt_pkg::REQ_RECLAIM, 4'd0,  16'h0000, 8'd1,  1'b0, '0},
            '{REQ_BAD_LO,            4'd10, 16'h1234, 8'd1,  1'b0, '0},
            '{REQ_BAD_MID,           4'd7,  16'hCAFE, 8'd1,  1'b0, '0},
            '{REQ_BAD_HI,            4'd15, 16'hFFFF, 8'd1,  1'b0, '0},
            '{egrt_pkg::REQ_RETIRE,  4'd0,  16'h1200, 8'd64, 1'b0, '0},
            '{egrt_pkg::REQ_RETIRE,  4'd0,  16'hBEEF, 8'd1,  1'b1,
              '{1'b0, 16'h0, 1'b1, 7'd64, 32'd4, 1'b1}},
            '{egrt_pkg::REQ_EXIT,    4'd5,  16'h0000, 8'd1,  1'b0, '0},
            '{egrt_pkg::REQ_RECLAIM, 4'd0,  16'h0000, 8'd1,  1'b0, '0},
            '{egrt_pkg::REQ_EXIT,    4'd15, 16'h0000, 8'd1,  1'b0, '0},
            '{egrt_pkg::REQ_RECLAIM, 4'd0,  16'h0000, 8'd1,  1'b0, '0},
            '{egrt_pkg::REQ_ENTER,   4'd15, 16'h0000, 8'd1,  1'b0, '0}
        };

        // slot count above the limit gets clamped; zero checks no slot
        phase_cfg   = '{16, 0, 1, 31, CFG_DRAW, CFG_DRAW, 16};
        phase_items = '{60, 40, 50, 90, 50, 50, 50};
        phase_mode  = '{MODE_MIX, MODE_MIX, MODE_MIX, MODE_FILL,
                        MODE_MIX, MODE_MIX, MODE_MIX};
        phase_burst = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};

        while (!i_rst_n) @(posedge i_clk);

        // directed table under the reset slot count; the typed rows replace
        // the model's single result with the hand-written one
        foreach (plan[s]) begin
            for (int k = 0; k < plan[s].reps; k++) begin
                send_request(plan[s].req, plan[s].tid,
                             plan[s].handle ^ egrt_pkg::HANDLE_W'(k));
                if (plan[s].typed) begin
                    void'(outcomes_due.pop_back());
                    outcomes_due.push_back(plan[s].want);
                end
            end
        end

        // random phases, each under its own slot count
        for (int p = 0; p < N_PHASES; p++) begin
            drain(4);
            no_idle = phase_burst[p];
            write_slots(phase_cfg[p] == CFG_DRAW ? egrt_pkg::ACT_W'($urandom_range(0, 31))
                                                 : egrt_pkg::ACT_W'(phase_cfg[p]));
            for (int n = 0; n < phase_items[p]; n++) begin
                r   = $urandom_range(0, 99);
                tid = egrt_pkg::TID_W'($urandom_range(0, N_SLOTS - 1));
                h   = egrt_pkg::HANDLE_W'($urandom);
                if (phase_mode[p] == MODE_FILL) begin
                    // pack the table past full with few reads in between
                    if (r < 85)      req = egrt_pkg::REQ_RETIRE;
                    else if (r < 93) req = egrt_pkg::REQ_ENTER;
                    else             req = egrt_pkg::REQ_ADVANCE;
                end else begin
                    if (r < 22)      req = egrt_pkg::REQ_ENTER;
                    else if (r < 42) req = egrt_pkg::REQ_EXIT;
                    else if (r < 58) req = egrt_pkg::REQ_ADVANCE;
                    else if (r < 82) req = egrt_pkg::REQ_RETIRE;
                    else if (r < 96) req = egrt_pkg::REQ_RECLAIM;
                    else req = egrt_pkg::REQ_W'($urandom_range(REQ_BAD_LO, REQ_BAD_HI));
                end
                send_request(req, tid, h);
            end
        end

        // empty the table so the longest reclaim chain runs at the end
        drain(4);
        no_idle = 1'b0;
        write_slots(egrt_pkg::ACT_W'(0));
        send_request(egrt_pkg::REQ_RECLAIM, '0, '0);
        drain(32);

        if (fail_count == 0)
            $display("epoch_grace_reclaim_tracker verification clean");
        else
            $display("epoch_grace_reclaim_tracker verification failed");
        $finish;
    end

endmodule
